// File: rtl/panel_register_guard_top_macros.svh
// Assertion macros for the panel register guard RTL.
`ifndef PANEL_REGISTER_GUARD_TOP_MACROS_SVH
`define PANEL_REGISTER_GUARD_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define PRG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("panel_register_guard assertion failed");

// Checked at every edge, reset included.
`define PRG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("panel_register_guard assertion failed");

`else

`define PRG_ASSERT(lbl, prop)
`define PRG_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: rtl/prg_pkg.sv
// Types, constants and codes shared by the panel register guard modules.
package prg_pkg;

  localparam int TimeBits = 32;

  typedef logic [TimeBits-1:0] time_t;

  localparam logic [7:0] StreakMax = 8'hFF;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_START  = 2'd1,
    MODE_REINIT = 2'd2,
    MODE_TAKE   = 2'd3
  } mode_e;

  // Configuration register indexes
  localparam logic [2:0] CfgShadow    = 3'd0;
  localparam logic [2:0] CfgDuty      = 3'd1;
  localparam logic [2:0] CfgSteady    = 3'd2;
  localparam logic [2:0] CfgFast      = 3'd3;
  localparam logic [2:0] CfgRelax     = 3'd4;
  localparam logic [2:0] CfgStreakLim = 3'd5;
  localparam logic [2:0] CfgCooldown  = 3'd6;
  localparam logic [2:0] CfgFeatures  = 3'd7;

  // Feature enable bits
  localparam int FeExpRead  = 0;
  localparam int FeExpWrite = 1;
  localparam int FeDutyRead = 2;
  localparam int FeDutyWrite = 3;
  localparam int FeReinit   = 4;

  typedef struct packed {
    logic [7:0]  shadow_value;
    logic [15:0] backlight_duty;
    logic [15:0] steady_period_ms;
    logic [15:0] fast_period_ms;
    logic [7:0]  clean_to_relax;
    logic [7:0]  anomaly_streak_limit;
    logic [31:0] reinit_cooldown_ms;
    logic [4:0]  feature_enables;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    time_t       now_ms;
    logic        expander_read_ok;
    logic [7:0]  expander_readback;
    logic [15:0] duty_readback;
  } item_t;

  typedef struct packed {
    logic        started;
    time_t       next_due_ms;
    logic [7:0]  bad_streak;
    logic [7:0]  clean_count;
    logic        in_fast;
    logic        request_pending;
    time_t       last_auto_ms;
    logic        ever_reinit;
  } state_t;

  typedef struct packed {
    logic        check_done;
    logic        found_bad;
    logic        expander_write;
    logic [7:0]  expander_write_value;
    logic        duty_write;
    logic [15:0] duty_write_value;
    logic        fast_mode;
    logic        reinit_raised;
    logic        request_taken;
  } result_t;

  // Wrap-safe deadline test: reached when (now - at) has its top bit clear.
  function automatic logic reached(time_t now, time_t at);
    time_t diff;
    diff = now - at;
    return ~diff[TimeBits-1];
  endfunction

endpackage

// File: rtl/panel_register_guard_top.sv
// Top level of the panel register guard: handshakes, registers and state.

// Panel register guard. Each input beat is one event (tick, start, reinit
// done, take request) and yields exactly one result beat. Throughput is one
// beat per clock while results are taken: an accepted beat is held in the
// input register, is evaluated there against the supervisor state by short
// compare and counter logic, and moves into the result register while the
// state updates in the same edge, so the next beat already sees it. The
// result register and the input register give two beats of buffering, so
// the input still takes one more beat while a result waits to be taken,
// then stalls until the result drains.
// Configuration is a plain write port
// (cfg_we_i, cfg_index_i, cfg_wdata_i) with no read-back; write it only while
// idle. Reset values: shadow 0, duty 0, steady period 2000 ms, fast period
// 200 ms, clean-to-relax 3, anomaly streak limit 3, cooldown 60000 ms, all
// features enabled.

`include "panel_register_guard_top_macros.svh"

module panel_register_guard_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  // event input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  prg_pkg::time_t      now_ms_i,
  input  logic                expander_read_ok_i,
  input  logic [7:0]          expander_readback_i,
  input  logic [15:0]         duty_readback_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                check_done_o,
  output logic                found_bad_o,
  output logic                expander_write_o,
  output logic [7:0]          expander_write_value_o,
  output logic                duty_write_o,
  output logic [15:0]         duty_write_value_o,
  output logic                fast_mode_o,
  output logic                reinit_raised_o,
  output logic                request_taken_o
);
  import prg_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q, st_d;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_d, res_q;
  logic    res_valid_q;
  logic    in_fire;
  logic    advance;

  // Held beat moves on when the result register is empty or being drained.
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shadow_value         <= 8'd0;
      cfg_q.backlight_duty       <= 16'd0;
      cfg_q.steady_period_ms     <= 16'd2000;
      cfg_q.fast_period_ms       <= 16'd200;
      cfg_q.clean_to_relax       <= 8'd3;
      cfg_q.anomaly_streak_limit <= 8'd3;
      cfg_q.reinit_cooldown_ms   <= 32'd60000;
      cfg_q.feature_enables      <= 5'h1F;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgShadow:    cfg_q.shadow_value         <= cfg_wdata_i[7:0];
        CfgDuty:      cfg_q.backlight_duty       <= cfg_wdata_i[15:0];
        CfgSteady:    cfg_q.steady_period_ms     <= cfg_wdata_i[15:0];
        CfgFast:      cfg_q.fast_period_ms       <= cfg_wdata_i[15:0];
        CfgRelax:     cfg_q.clean_to_relax       <= cfg_wdata_i[7:0];
        CfgStreakLim: cfg_q.anomaly_streak_limit <= cfg_wdata_i[7:0];
        CfgCooldown:  cfg_q.reinit_cooldown_ms   <= cfg_wdata_i;
        CfgFeatures:  cfg_q.feature_enables      <= cfg_wdata_i[4:0];
        default:      cfg_q                      <= cfg_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode              <= mode_e'(mode_i);
      item_q.now_ms            <= now_ms_i;
      item_q.expander_read_ok  <= expander_read_ok_i;
      item_q.expander_readback <= expander_readback_i;
      item_q.duty_readback     <= duty_readback_i;
    end
  end

  // Event evaluation
  prg_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .item_i   (item_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  // Supervisor state commits when the beat moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = res_valid_q;
  assign check_done_o           = res_q.check_done;
  assign found_bad_o            = res_q.found_bad;
  assign expander_write_o       = res_q.expander_write;
  assign expander_write_value_o = res_q.expander_write_value;
  assign duty_write_o           = res_q.duty_write;
  assign duty_write_value_o     = res_q.duty_write_value;
  assign fast_mode_o            = res_q.fast_mode;
  assign reinit_raised_o        = res_q.reinit_raised;
  assign request_taken_o        = res_q.request_taken;

  // A raised reinit leaves a pending request behind.
  `PRG_ASSERT(a_raise_sets_pending, (advance && res_d.reinit_raised) |=> st_q.request_pending)
  // Taking the request always clears it.
  `PRG_ASSERT(a_take_clears, (advance && item_q.mode == MODE_TAKE) |=> !st_q.request_pending)
  // Rewrites only come out of a check that found a mismatch.
  `PRG_ASSERT(a_write_needs_bad,
              (res_valid_q && (res_q.expander_write || res_q.duty_write)) |->
              (res_q.check_done && res_q.found_bad))
  // Input stalls only with both registers full and the output blocked.
  `PRG_ASSERT_ALWAYS(a_stall_cause,
                     !in_ready_o |-> (item_valid_q && res_valid_q && !out_ready_i))

endmodule

// File: rtl/prg_step.sv
// One event step: next supervisor state and the result beat for one item.
module prg_step (
  input  prg_pkg::cfg_t    cfg_i,
  input  prg_pkg::state_t  state_i,
  input  prg_pkg::item_t   item_i,
  output prg_pkg::state_t  state_o,
  output prg_pkg::result_t result_o
);
  import prg_pkg::*;

  logic       due;
  logic       murky;
  logic       exp_bad;
  logic       duty_bad;
  logic       bad;
  logic [7:0] streak_inc;
  logic [7:0] clean_inc;
  logic [7:0] streak_nxt;
  logic [7:0] clean_nxt;
  logic       fast_nxt;
  logic       cooled;
  logic       raise;
  time_t      steady_due;
  time_t      check_due;

  always_comb begin
    due      = state_i.started && reached(item_i.now_ms, state_i.next_due_ms);
    murky    = cfg_i.feature_enables[FeExpRead] && !item_i.expander_read_ok;
    exp_bad  = cfg_i.feature_enables[FeExpRead] && item_i.expander_read_ok &&
               (item_i.expander_readback != cfg_i.shadow_value);
    duty_bad = cfg_i.feature_enables[FeDutyRead] &&
               (item_i.duty_readback != cfg_i.backlight_duty);
    bad      = exp_bad || duty_bad;

    streak_inc = (state_i.bad_streak != StreakMax) ? state_i.bad_streak + 8'd1
                                                   : state_i.bad_streak;
    clean_inc  = (state_i.clean_count != StreakMax) ? state_i.clean_count + 8'd1
                                                    : state_i.clean_count;
    streak_nxt = bad ? streak_inc : 8'd0;
    clean_nxt  = bad ? 8'd0 : clean_inc;
    fast_nxt   = bad || murky || (clean_nxt <= cfg_i.clean_to_relax);

    // First automatic request needs no cooldown.
    cooled = !state_i.ever_reinit ||
             reached(item_i.now_ms,
                     state_i.last_auto_ms + TimeBits'(cfg_i.reinit_cooldown_ms));
    raise  = (streak_nxt >= cfg_i.anomaly_streak_limit) &&
             cfg_i.feature_enables[FeReinit] && cooled;

    steady_due = item_i.now_ms + TimeBits'(cfg_i.steady_period_ms);
    check_due  = item_i.now_ms + TimeBits'(fast_nxt ? cfg_i.fast_period_ms
                                                    : cfg_i.steady_period_ms);
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (item_i.mode)
      MODE_TICK: begin
        if (due) begin
          state_o.bad_streak  = raise ? 8'd0 : streak_nxt;
          state_o.clean_count = clean_nxt;
          state_o.in_fast     = fast_nxt;
          state_o.next_due_ms = check_due;
          if (raise) begin
            state_o.request_pending = 1'b1;
            state_o.ever_reinit     = 1'b1;
            state_o.last_auto_ms    = item_i.now_ms;
          end
          result_o.check_done     = 1'b1;
          result_o.found_bad      = bad;
          result_o.reinit_raised  = raise;
          result_o.expander_write = exp_bad && cfg_i.feature_enables[FeExpWrite];
          result_o.duty_write     = duty_bad && cfg_i.feature_enables[FeDutyWrite];
          result_o.expander_write_value =
            result_o.expander_write ? cfg_i.shadow_value : 8'd0;
          result_o.duty_write_value =
            result_o.duty_write ? cfg_i.backlight_duty : 16'd0;
        end
      end
      MODE_START: begin
        state_o.started         = 1'b1;
        state_o.next_due_ms     = steady_due;
        state_o.bad_streak      = 8'd0;
        state_o.clean_count     = 8'd0;
        state_o.in_fast         = 1'b0;
        state_o.request_pending = 1'b0;
      end
      MODE_REINIT: begin
        state_o.bad_streak      = 8'd0;
        state_o.clean_count     = 8'd0;
        state_o.in_fast         = 1'b0;
        state_o.request_pending = 1'b0;
        state_o.last_auto_ms    = item_i.now_ms;
        state_o.next_due_ms     = steady_due;
      end
      MODE_TAKE: begin
        result_o.request_taken  = state_i.request_pending;
        state_o.request_pending = 1'b0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
    result_o.fast_mode = state_o.in_fast;
  end

endmodule
